[rtl/bsm_pkg.sv]
package bsm_pkg;

  // default sizes
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int DIST_BITS_DEF   = 31;

  // fixed field widths of the stream payloads
  localparam int IDX_W    = 8;
  localparam int PROP_W   = 3;
  localparam int DIST_W   = 31;
  localparam int CNT_W    = 5;
  localparam int ACC_W    = 7;
  localparam int ECOUNT_W = 9;
  localparam int CFG_A_W  = 1;
  localparam int CFG_D_W  = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam int ACC_RESET = 50;
  localparam int PCT_SCALE = 100;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_ACCURACY = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_COUNT    = 1'b1;

  // item kinds carried on in_tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } bsm_state_t;

  // population count of up to 64 bits
  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

endpackage

[rtl/bitset_similarity_best_match_top.sv]
// Best-match search over a table of bit-vector entries. Each in_ transaction is a
// write (tuser 0) that stores property flags and a distance set in slot entry_index,
// or a query (tuser 1) that returns one out_ transaction naming the entry with the
// highest overlap score common/larger among entries 0..entry_count-1 whose flags equal
// the query's; a candidate needs 100*common >= accuracy_percent*larger and common > 0,
// scores are compared by cross-multiplication and ties keep the lowest slot. A query
// scans its entries with one table read port feeding one popcount-and-compare unit,
// one entry per cycle, behind a three-stage read/count/update pipeline. in_tready
// stays low while a query is being scanned; the finished result sits in an output
// register, so the next item may be accepted while it waits. Slots must be written
// before a query scans them. Configuration writes are applied on any cycle with
// cfg_we high and must only be made while the block is idle.
module bitset_similarity_best_match_top
  import bsm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int DIST_BITS   = DIST_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tdata: entry_index[7:0], property_flags[10:8], distance_bits[41:11], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: action
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: found[0], best_index[8:1], match_count[13:9], larger_count[18:14], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_A_W-1:0]     cfg_addr,
  input  logic [CFG_D_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;  // slot address
  localparam int CW = $clog2(MAX_ENTRIES + 1);                       // scan counter
  localparam int DW = DIST_BITS;
  localparam int PW = $clog2(DIST_BITS + 1);                         // popcount width
  localparam int MW = PW + ACC_W;                                    // threshold products
  localparam int XW = 2 * PW;                                        // cross products
  localparam int EW = DW + PROP_W;                                   // table word

  // input field split
  logic [IDX_W-1:0]  in_idx;
  logic [PROP_W-1:0] in_props;
  logic [DW-1:0]     in_dists;

  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_props = in_tdata[IDX_W+PROP_W-1:IDX_W];
  assign in_dists = DW'(in_tdata[IDX_W+PROP_W+DIST_W-1:IDX_W+PROP_W]);

  // configuration registers
  logic [ACC_W-1:0]    acc_r;
  logic [ECOUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= ACC_W'(ACC_RESET);
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACCURACY: acc_r   <= cfg_wdata[ACC_W-1:0];
        REG_COUNT:    count_r <= cfg_wdata[ECOUNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // sequencer and pipeline registers
  bsm_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic          v1_r, v1_nxt;     // table word valid
  logic          v2_r;             // popcounts valid
  logic [AW-1:0] idx1_r, idx2_r;
  logic          found_r, found_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [PW-1:0] best_m_r, best_m_nxt;
  logic [PW-1:0] best_l_r, best_l_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // query held for the whole scan
  logic [DW-1:0]     q_dists_r;
  logic [PROP_W-1:0] q_props_r;
  logic [PW-1:0]     qcount_r;

  // stage 2 payload
  logic          pmatch2_r;
  logic [PW-1:0] ecount2_r;
  logic [PW-1:0] m2_r;

  logic in_fire;
  logic mem_we;
  logic [CW-1:0] limit_in;
  logic [EW-1:0] rd_data;
  logic [PROP_W-1:0] rd_props;
  logic [DW-1:0] rd_dists;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign mem_we     = in_fire && (in_tuser == ACT_WRITE) &&
                      (32'(in_idx) < 32'(MAX_ENTRIES));
  assign limit_in   = (32'(count_r) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  bsm_mem #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (AW),
    .WIDTH  (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_idx)),
    .wr_data ({in_props, in_dists}),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_props = rd_data[EW-1:DW];
  assign rd_dists = rd_data[DW-1:0];

  // stage 3: shared score unit, one entry per cycle
  logic [PW-1:0] l3;
  logic [MW-1:0] pct_lhs, pct_rhs;
  logic [XW-1:0] x_new, x_best;
  logic          qualify;

  always_comb begin
    l3      = (qcount_r > ecount2_r) ? qcount_r : ecount2_r;
    pct_lhs = MW'(m2_r) * MW'(PCT_SCALE);
    pct_rhs = MW'(acc_r) * MW'(l3);
    x_new   = XW'(m2_r) * XW'(best_l_r);
    x_best  = XW'(best_m_r) * XW'(l3);
    qualify = v2_r && pmatch2_r && (l3 != '0) && (m2_r != '0) &&
              (pct_lhs >= pct_rhs) && (!found_r || (x_new > x_best));
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    v1_nxt        = 1'b0;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_m_nxt    = best_m_r;
    best_l_nxt    = best_l_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (qualify) begin
      found_nxt  = 1'b1;
      best_nxt   = idx2_r;
      best_m_nxt = m2_r;
      best_l_nxt = l3;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == ACT_QUERY)) begin
          cnt_nxt    = '0;
          limit_nxt  = limit_in;
          found_nxt  = 1'b0;
          best_nxt   = '0;
          best_m_nxt = '0;
          best_l_nxt = '0;
          state_nxt  = (limit_in == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read issued at cnt_r this cycle
        v1_nxt  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if ((cnt_r + CW'(1)) == limit_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_TDATA_W - 1 - IDX_W - 2 * CNT_W){1'b0}},
                           CNT_W'(best_l_r), CNT_W'(best_m_r), IDX_W'(best_r), found_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      limit_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      limit_r     <= limit_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser == ACT_QUERY)) begin
      q_dists_r <= in_dists;
      q_props_r <= in_props;
      qcount_r  <= PW'(popcount64(64'(in_dists)));
    end
    idx1_r     <= cnt_r[AW-1:0];
    idx2_r     <= idx1_r;
    pmatch2_r  <= (rd_props == q_props_r);
    ecount2_r  <= PW'(popcount64(64'(rd_dists)));
    m2_r       <= PW'(popcount64(64'(rd_dists & q_dists_r)));
    best_r     <= best_nxt;
    best_m_r   <= best_m_nxt;
    best_l_r   <= best_l_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/bsm_mem.sv]
module bsm_mem
  import bsm_pkg::*;
#(
  parameter int DEPTH  = MAX_ENTRIES_DEF,
  parameter int ADDR_W = 8,
  parameter int WIDTH  = DIST_BITS_DEF + PROP_W
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/bsm_checker.sv]
module bsm_checker
  import bsm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic                   cfg_we,
  input logic [CFG_A_W-1:0]     cfg_addr,
  input logic [CFG_D_W-1:0]     cfg_wdata
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no winner reports all-zero fields
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[18:1] == '0)
    else $error("fields set without a winner");

  // a winner has nonzero overlap no larger than the larger count
  a_winner_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      out_tdata[13:9] != '0 && out_tdata[13:9] <= out_tdata[18:14])
    else $error("winner counts inconsistent");

  // a query keeps the input side busy while it scans
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_QUERY |=> !in_tready)
    else $error("ready during query scan");

  // a table write leaves the input side ready in the next cycle
  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_WRITE |=> in_tready)
    else $error("busy after table write");

endmodule

bind bitset_similarity_best_match_top bsm_checker u_bsm_checker (.*);
